// ===== rtl/hfl_pkg.sv =====
//------------------------------------------------------------------------------
// hfl_pkg
// Shared types and constants for the range-hood controller.
//------------------------------------------------------------------------------
package hfl_pkg;

  typedef enum logic [1:0] {
    OP_STEP = 2'd0,
    OP_TICK50 = 2'd1,
    OP_TICK1S = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_BLOW = 3'd1,
    M_BLOW_AUTO = 3'd2,
    M_CLK_EDIT = 3'd3,
    M_AUTO_EDIT = 3'd4,
    M_DELAY_EDIT = 3'd5,
    M_BAD6 = 3'd6,
    M_BAD7 = 3'd7
  } mode_t;

  localparam int unsigned K_LIGHT = 0;
  localparam int unsigned K_TIMER = 1;
  localparam int unsigned K_PLUS = 2;
  localparam int unsigned K_MINUS = 3;

  localparam logic [1:0] BEEP_NONE = 2'd0;
  localparam logic [1:0] BEEP_ONE = 2'd1;
  localparam logic [1:0] BEEP_TWO = 2'd2;

  localparam logic [1:0] REG_WMODE = 2'd0;
  localparam logic [1:0] REG_SHORT = 2'd1;
  localparam logic [1:0] REG_LONG = 2'd2;
  localparam logic [1:0] REG_LIMIT = 2'd3;

  localparam logic [9:0] DELAY_MAX = 10'd900;
  localparam logic [9:0] DELAY_HI = 10'd840;
  localparam logic [9:0] DELAY_LO = 10'd120;
  localparam logic [9:0] DELAY_MIN = 10'd60;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] key_press;
    logic [3:0] key_hold;
    logic [3:0] key_release;
    logic [3:0] key_touch;
    logic timer_held_late;
    logic clock_pulse_level;
  } in_item_t;

  typedef struct packed {
    logic [3:0] fan_drive;
    logic lamp_on;
    logic led_on;
    logic [1:0] beep;
    logic [2:0] mode_state;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
    logic [4:0] edit_hour;
    logic [5:0] edit_minute;
    logic [9:0] off_delay_seconds;
    logic [9:0] off_remain_seconds;
    logic [31:0] run_seconds_total;
  } out_item_t;

  typedef struct packed {
    logic key_scheme;
    logic [7:0] short_tick_len;
    logic [7:0] long_tick_len;
    logic [15:0] run_limit_seconds;
  } cfg_t;

endpackage

// ===== rtl/hfl_if.sv =====
//------------------------------------------------------------------------------
// hfl_in_if / hfl_out_if
// Valid/ready channels carrying input and result items.
//------------------------------------------------------------------------------
interface hfl_in_if;
  import hfl_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hfl_out_if;
  import hfl_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/hfl_cfg.sv =====
//------------------------------------------------------------------------------
// hfl_cfg
// APB-style configuration register file.
//------------------------------------------------------------------------------
module hfl_cfg (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output hfl_pkg::cfg_t cfg
);
  import hfl_pkg::*;

  logic wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign idx = paddr[3:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_scheme <= 1'b1;
      cfg.short_tick_len <= 8'd4;
      cfg.long_tick_len <= 8'd100;
      cfg.run_limit_seconds <= 16'd10800;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (idx)
        REG_WMODE: cfg.key_scheme <= pwdata[0];
        REG_SHORT: cfg.short_tick_len <= pwdata[7:0];
        REG_LONG: cfg.long_tick_len <= pwdata[7:0];
        REG_LIMIT: cfg.run_limit_seconds <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (idx)
      REG_WMODE: prdata = {31'd0, cfg.key_scheme};
      REG_SHORT: prdata = {24'd0, cfg.short_tick_len};
      REG_LONG: prdata = {24'd0, cfg.long_tick_len};
      REG_LIMIT: prdata = {16'd0, cfg.run_limit_seconds};
      default: prdata = 32'd0;
    endcase
  end
endmodule

// ===== rtl/hfl_core.sv =====
//------------------------------------------------------------------------------
// hfl_core
// Controller state and the single-pass next-state logic for one item.
//------------------------------------------------------------------------------
module hfl_core (
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  hfl_pkg::in_item_t item,
  input  hfl_pkg::cfg_t cfg,
  output hfl_pkg::out_item_t result
);
  import hfl_pkg::*;

  mode_t mode_reg, mode_reg_next;
  logic mode_changed, mode_changed_next;
  logic [2:0] fan_speed, fan_speed_next, previous_speed, previous_speed_next;
  logic lamp_reg, lamp_reg_next, led_reg, led_reg_next;
  logic [9:0] delay_seconds, delay_seconds_next, remain_seconds, remain_seconds_next;
  logic [31:0] total_run_seconds, total_run_seconds_next;
  logic [15:0] idle_cutoff_count, idle_cutoff_count_next;
  logic [7:0] short_count, short_count_next, long_count, long_count_next;
  logic [5:0] second_reg, second_reg_next, minute_reg, minute_reg_next;
  logic [4:0] hour_reg, hour_reg_next;
  logic pulse_last, pulse_last_next;
  logic [4:0] edit_hour_reg, edit_hour_reg_next;
  logic [5:0] edit_minute_reg, edit_minute_reg_next;
  logic edit_stage, edit_stage_next;
  logic [1:0] beep_next;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= M_IDLE;
      mode_changed <= 1'b0;
      fan_speed <= 3'd1;
      previous_speed <= 3'd1;
      lamp_reg <= 1'b0;
      led_reg <= 1'b0;
      delay_seconds <= DELAY_MIN;
      remain_seconds <= 10'd0;
      total_run_seconds <= 32'd0;
      idle_cutoff_count <= 16'd10800;
      short_count <= 8'd0;
      long_count <= 8'd0;
      second_reg <= 6'd0;
      minute_reg <= 6'd0;
      hour_reg <= 5'd12;
      pulse_last <= 1'b0;
      edit_hour_reg <= 5'd0;
      edit_minute_reg <= 6'd0;
      edit_stage <= 1'b0;
    end else if (take) begin
      mode_reg <= mode_reg_next;
      mode_changed <= mode_changed_next;
      fan_speed <= fan_speed_next;
      previous_speed <= previous_speed_next;
      lamp_reg <= lamp_reg_next;
      led_reg <= led_reg_next;
      delay_seconds <= delay_seconds_next;
      remain_seconds <= remain_seconds_next;
      total_run_seconds <= total_run_seconds_next;
      idle_cutoff_count <= idle_cutoff_count_next;
      short_count <= short_count_next;
      long_count <= long_count_next;
      second_reg <= second_reg_next;
      minute_reg <= minute_reg_next;
      hour_reg <= hour_reg_next;
      pulse_last <= pulse_last_next;
      edit_hour_reg <= edit_hour_reg_next;
      edit_minute_reg <= edit_minute_reg_next;
      edit_stage <= edit_stage_next;
    end
  end

  // Next-state logic, written in the order the steps take effect.
  always_comb begin
    logic [3:0] pr, hd, rl;
    logic tc, stick, ltick, up, dn, was_blow;
    logic [2:0] start_speed, last_speed;
    mode_reg_next = mode_reg;
    mode_changed_next = mode_changed;
    fan_speed_next = fan_speed;
    previous_speed_next = previous_speed;
    lamp_reg_next = lamp_reg;
    led_reg_next = led_reg;
    delay_seconds_next = delay_seconds;
    remain_seconds_next = remain_seconds;
    total_run_seconds_next = total_run_seconds;
    idle_cutoff_count_next = idle_cutoff_count;
    short_count_next = short_count;
    long_count_next = long_count;
    second_reg_next = second_reg;
    minute_reg_next = minute_reg;
    hour_reg_next = hour_reg;
    pulse_last_next = pulse_last;
    edit_hour_reg_next = edit_hour_reg;
    edit_minute_reg_next = edit_minute_reg;
    edit_stage_next = edit_stage;
    beep_next = BEEP_NONE;
    pr = item.key_press;
    hd = item.key_hold;
    rl = item.key_release;
    tc = |item.key_touch;
    start_speed = fan_speed;
    last_speed = previous_speed;
    stick = 1'b0;
    ltick = 1'b0;
    up = 1'b0;
    dn = 1'b0;
    was_blow = 1'b0;

    unique case (op_t'(item.opcode))
      OP_STEP: begin
        if (short_count == 8'd0) begin
          short_count_next = cfg.short_tick_len;
          stick = 1'b1;
        end
        if (long_count == 8'd0) begin
          long_count_next = cfg.long_tick_len;
          ltick = 1'b1;
        end
        up = pr[K_PLUS] || (hd[K_PLUS] && stick);
        dn = pr[K_MINUS] || (hd[K_MINUS] && stick);
        if (mode_reg != M_CLK_EDIT && pr[K_LIGHT]) begin
          beep_next = BEEP_ONE;
          lamp_reg_next = ~lamp_reg;
        end
        led_reg_next = !(mode_reg == M_IDLE && !lamp_reg_next && hd == 4'd0);
        if (tc) begin
          idle_cutoff_count_next = cfg.run_limit_seconds;
          long_count_next = cfg.long_tick_len;
        end
        if (!cfg.key_scheme) begin
          // Clock scheme: the wall clock follows the 1 Hz level.
          if (item.clock_pulse_level != pulse_last) begin
            pulse_last_next = item.clock_pulse_level;
            if (second_reg == 6'd59) begin
              second_reg_next = 6'd0;
              if (minute_reg == 6'd59) begin
                minute_reg_next = 6'd0;
                hour_reg_next = (hour_reg == 5'd23) ? 5'd0 : hour_reg + 5'd1;
              end else begin
                minute_reg_next = minute_reg + 6'd1;
              end
            end else begin
              second_reg_next = second_reg + 6'd1;
            end
          end
          unique case (mode_reg)
            M_IDLE: begin
              fan_speed_next = 3'd0;
              if (pr[K_TIMER]) begin
                beep_next = BEEP_ONE;
                edit_hour_reg_next = hour_reg_next;
                edit_minute_reg_next = minute_reg_next;
                edit_stage_next = 1'b0;
                mode_changed_next = (mode_reg_next != M_CLK_EDIT);
                mode_reg_next = M_CLK_EDIT;
              end
              if (pr[K_PLUS]) begin
                beep_next = BEEP_ONE;
                mode_changed_next = (mode_reg_next != M_BLOW);
                mode_reg_next = M_BLOW;
                fan_speed_next = 3'd1;
              end
              if (pr[K_MINUS]) begin
                beep_next = BEEP_ONE;
                mode_changed_next = (mode_reg_next != M_BLOW);
                mode_reg_next = M_BLOW;
                fan_speed_next = 3'd4;
              end
            end
            M_CLK_EDIT: begin
              fan_speed_next = 3'd0;
              if (!edit_stage) begin
                if (ltick || pr[K_TIMER]) begin
                  edit_stage_next = 1'b1;
                  long_count_next = cfg.long_tick_len;
                  beep_next = BEEP_ONE;
                end
                if (up) begin
                  beep_next = BEEP_ONE;
                  edit_hour_reg_next = (edit_hour_reg == 5'd23) ? 5'd0 : edit_hour_reg + 5'd1;
                end
                if (dn) begin
                  beep_next = BEEP_ONE;
                  edit_hour_reg_next = (edit_hour_reg_next == 5'd0) ? 5'd23
                                     : edit_hour_reg_next - 5'd1;
                end
              end else begin
                if (ltick || pr[K_TIMER]) begin
                  mode_reg_next = M_IDLE;
                  mode_changed_next = 1'b1;
                  minute_reg_next = edit_minute_reg;
                  hour_reg_next = edit_hour_reg;
                  second_reg_next = 6'd0;
                  beep_next = BEEP_TWO;
                end
                if (up) begin
                  if (beep_next == BEEP_NONE) beep_next = BEEP_ONE;
                  edit_minute_reg_next = (edit_minute_reg == 6'd59) ? 6'd0
                                       : edit_minute_reg + 6'd1;
                end
                if (dn) begin
                  if (beep_next == BEEP_NONE) beep_next = BEEP_ONE;
                  edit_minute_reg_next = (edit_minute_reg_next == 6'd0) ? 6'd59
                                       : edit_minute_reg_next - 6'd1;
                end
              end
            end
            M_BLOW: begin
              if (pr[K_TIMER]) begin
                beep_next = BEEP_ONE;
                delay_seconds_next = DELAY_MIN;
                mode_reg_next = M_AUTO_EDIT;
                mode_changed_next = 1'b1;
              end
              if (pr[K_PLUS]) begin
                beep_next = BEEP_ONE;
                if (fan_speed_next == 3'd4) begin
                  fan_speed_next = 3'd0;
                  mode_changed_next = (mode_reg_next != M_IDLE);
                  mode_reg_next = M_IDLE;
                end else begin
                  fan_speed_next = (fan_speed_next + 3'd1 <= 3'd4) ? fan_speed_next + 3'd1 : 3'd0;
                end
              end
              if (pr[K_MINUS]) begin
                beep_next = BEEP_ONE;
                if (fan_speed_next == 3'd1) begin
                  fan_speed_next = 3'd0;
                  mode_changed_next = (mode_reg_next != M_IDLE);
                  mode_reg_next = M_IDLE;
                end else if (fan_speed_next == 3'd0) begin
                  fan_speed_next = 3'd0;
                end else begin
                  fan_speed_next = (fan_speed_next - 3'd1 <= 3'd4) ? fan_speed_next - 3'd1 : 3'd0;
                end
              end
            end
            M_AUTO_EDIT: begin
              if (ltick) begin
                remain_seconds_next = delay_seconds;
                mode_reg_next = M_BLOW_AUTO;
                mode_changed_next = 1'b1;
                beep_next = BEEP_TWO;
              end
              if (pr[K_TIMER]) begin
                if (beep_next == BEEP_NONE) beep_next = BEEP_ONE;
                mode_changed_next = (mode_reg_next != M_BLOW);
                mode_reg_next = M_BLOW;
              end
              if (up) begin
                if (beep_next == BEEP_NONE) beep_next = BEEP_ONE;
                delay_seconds_next = (delay_seconds > DELAY_HI) ? DELAY_MIN
                                   : delay_seconds + DELAY_MIN;
              end
              if (dn) begin
                if (beep_next == BEEP_NONE) beep_next = BEEP_ONE;
                delay_seconds_next = (delay_seconds_next < DELAY_LO) ? DELAY_MAX
                                   : delay_seconds_next - DELAY_MIN;
              end
            end
            M_BLOW_AUTO: begin
              if (remain_seconds == 10'd0) begin
                beep_next = BEEP_ONE;
                mode_reg_next = M_IDLE;
                mode_changed_next = 1'b1;
                lamp_reg_next = 1'b0;
              end
              if (pr[K_PLUS]) begin
                beep_next = BEEP_ONE;
                if (fan_speed_next == 3'd4) begin
                  fan_speed_next = 3'd0;
                  mode_changed_next = (mode_reg_next != M_IDLE);
                  mode_reg_next = M_IDLE;
                end else begin
                  fan_speed_next = (fan_speed_next + 3'd1 <= 3'd4) ? fan_speed_next + 3'd1 : 3'd0;
                end
              end
              if (pr[K_MINUS]) begin
                beep_next = BEEP_ONE;
                if (fan_speed_next == 3'd1) begin
                  fan_speed_next = 3'd0;
                  mode_changed_next = (mode_reg_next != M_IDLE);
                  mode_reg_next = M_IDLE;
                end else if (fan_speed_next == 3'd0) begin
                  fan_speed_next = 3'd0;
                end else begin
                  fan_speed_next = (fan_speed_next - 3'd1 <= 3'd4) ? fan_speed_next - 3'd1 : 3'd0;
                end
              end
              if (rl[K_TIMER] && !item.timer_held_late) begin
                beep_next = BEEP_ONE;
                mode_changed_next = (mode_reg_next != M_BLOW);
                mode_reg_next = M_BLOW;
              end
            end
            default: begin
              mode_changed_next = (mode_reg != M_IDLE);
              mode_reg_next = M_IDLE;
            end
          endcase
        end else begin
          // Run-time scheme.
          unique case (mode_reg)
            M_DELAY_EDIT: begin
              fan_speed_next = 3'd0;
              if (tc) long_count_next = cfg.long_tick_len;
              if (ltick && !mode_changed) begin
                beep_next = BEEP_ONE;
                mode_reg_next = M_IDLE;
                mode_changed_next = 1'b1;
              end
              if (pr[K_PLUS]) begin
                beep_next = BEEP_ONE;
                delay_seconds_next = (delay_seconds_next == DELAY_MAX) ? DELAY_MIN
                                   : delay_seconds_next + DELAY_MIN;
              end
              if (hd[K_PLUS] && stick) begin
                beep_next = BEEP_ONE;
                delay_seconds_next = (delay_seconds_next == DELAY_MAX) ? DELAY_MIN
                                   : delay_seconds_next + DELAY_MIN;
              end
              if (pr[K_MINUS]) begin
                beep_next = BEEP_ONE;
                delay_seconds_next = (delay_seconds_next == DELAY_MIN) ? DELAY_MAX
                                   : delay_seconds_next - DELAY_MIN;
              end
              if (hd[K_MINUS] && !mode_changed_next && stick) begin
                beep_next = BEEP_ONE;
                delay_seconds_next = (delay_seconds_next == DELAY_MIN) ? DELAY_MAX
                                   : delay_seconds_next - DELAY_MIN;
              end
              if (pr[K_TIMER]) begin
                beep_next = BEEP_ONE;
                mode_changed_next = (mode_reg_next != M_IDLE);
                mode_reg_next = M_IDLE;
              end
              if (rl[K_MINUS] && mode_changed_next) begin
                mode_changed_next = 1'b0;
                long_count_next = cfg.long_tick_len;
              end
            end
            M_IDLE: begin
              fan_speed_next = 3'd0;
              if (pr[K_TIMER]) begin
                beep_next = BEEP_ONE;
                mode_changed_next = 1'b1;
                mode_reg_next = M_BLOW;
                fan_speed_next = (last_speed >= 3'd1 && last_speed <= 3'd4) ? last_speed : 3'd0;
              end
              if (hd[K_PLUS]) begin
                beep_next = BEEP_ONE;
                total_run_seconds_next = 32'd0;
                mode_changed_next = (mode_reg_next != M_BLOW);
                mode_reg_next = M_BLOW;
                fan_speed_next = (last_speed >= 3'd1 && last_speed <= 3'd4) ? last_speed : 3'd0;
              end
              if (hd[K_MINUS]) begin
                beep_next = BEEP_ONE;
                mode_changed_next = (mode_reg_next != M_DELAY_EDIT);
                mode_reg_next = M_DELAY_EDIT;
              end
            end
            M_BLOW, M_BLOW_AUTO: begin
              if (mode_reg == M_BLOW_AUTO && remain_seconds == 10'd0) begin
                beep_next = BEEP_ONE;
                mode_reg_next = M_IDLE;
                mode_changed_next = 1'b1;
                lamp_reg_next = 1'b0;
              end
              was_blow = (mode_reg_next == M_BLOW);
              if (pr[K_PLUS]) begin
                beep_next = BEEP_ONE;
                fan_speed_next = (fan_speed_next == 3'd4) ? 3'd1
                               : ((fan_speed_next + 3'd1 <= 3'd4) ? fan_speed_next + 3'd1 : 3'd0);
              end
              if (pr[K_MINUS]) begin
                beep_next = BEEP_ONE;
                if (fan_speed_next == 3'd1) fan_speed_next = 3'd4;
                else if (fan_speed_next == 3'd0) fan_speed_next = 3'd0;
                else fan_speed_next = (fan_speed_next - 3'd1 <= 3'd4) ? fan_speed_next - 3'd1
                                                                      : 3'd0;
              end
              if (rl[K_TIMER] && !mode_changed_next) begin
                beep_next = BEEP_ONE;
                mode_changed_next = (mode_reg_next != M_IDLE);
                mode_reg_next = M_IDLE;
              end
              if (was_blow && hd[K_TIMER] && !mode_changed_next) begin
                beep_next = BEEP_ONE;
                mode_changed_next = (mode_reg_next != M_BLOW_AUTO);
                mode_reg_next = M_BLOW_AUTO;
                remain_seconds_next = delay_seconds_next;
              end
              if (rl[K_TIMER] && mode_changed_next) mode_changed_next = 1'b0;
              if (start_speed < 3'd5) previous_speed_next = start_speed;
            end
            default: begin
              mode_changed_next = (mode_reg != M_IDLE);
              mode_reg_next = M_IDLE;
            end
          endcase
        end
      end
      OP_TICK50: begin
        if (short_count != 8'd0) short_count_next = short_count - 8'd1;
        if (long_count != 8'd0) long_count_next = long_count - 8'd1;
      end
      OP_TICK1S: begin
        if (mode_reg == M_BLOW || mode_reg == M_BLOW_AUTO) begin
          total_run_seconds_next = total_run_seconds + 32'd1;
          if (idle_cutoff_count == 16'd0) begin
            beep_next = BEEP_ONE;
            mode_reg_next = M_IDLE;
            mode_changed_next = 1'b1;
            lamp_reg_next = 1'b0;
          end else begin
            idle_cutoff_count_next = idle_cutoff_count - 16'd1;
          end
        end
        if (mode_reg == M_BLOW_AUTO && remain_seconds != 10'd0)
          remain_seconds_next = remain_seconds - 10'd1;
      end
      default: ;
    endcase
  end

  // Snapshot of the outputs after this item.
  always_comb begin
    unique case (fan_speed_next)
      3'd1: result.fan_drive = 4'b0001;
      3'd2: result.fan_drive = 4'b0010;
      3'd3: result.fan_drive = 4'b0100;
      3'd4: result.fan_drive = 4'b1000;
      default: result.fan_drive = 4'b0000;
    endcase
    result.lamp_on = lamp_reg_next;
    result.led_on = led_reg_next;
    result.beep = beep_next;
    result.mode_state = mode_reg_next;
    result.clock_hour = hour_reg_next;
    result.clock_minute = minute_reg_next;
    result.edit_hour = edit_hour_reg_next;
    result.edit_minute = edit_minute_reg_next;
    result.off_delay_seconds = delay_seconds_next;
    result.off_remain_seconds = remain_seconds_next;
    result.run_seconds_total = total_run_seconds_next;
  end

  // Checks on the controller state.
  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    fan_speed <= 3'd4) else $error("fan speed out of range");
  a_delay_range: assert property (@(posedge clk) disable iff (rst)
    delay_seconds <= DELAY_MAX) else $error("delay out of range");
  a_hour_range: assert property (@(posedge clk) disable iff (rst)
    hour_reg <= 5'd23) else $error("hour out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(total_run_seconds) && $stable(mode_reg))
    else $error("state changed without an item");
endmodule

// ===== rtl/hood_fan_lamp_controller_top.sv =====
//------------------------------------------------------------------------------
// hood_fan_lamp_controller_top
// Range-hood controller: fan, lamp, auto-off, run time and wall clock.
//
//   channel  | dir | handshake        | payload
//   in_ch    | in  | valid / ready    | opcode, keys, late hold, 1 Hz level
//   out_ch   | out | valid / ready    | fan, lamp, LED, beep, mode, clock, timers
//   apb      | in  | psel / penable   | four configuration registers
//
// One item per cycle while the receiver keeps up: state updates at the accept edge
// and the result sits in a single output register on the next cycle. Input ready
// is high whenever the output register is empty or is being drained in the same
// cycle. Reset is synchronous and active high.
//------------------------------------------------------------------------------
module hood_fan_lamp_controller_top (
  input  logic clk,
  input  logic rst,
  hfl_in_if.sink in_ch,
  hfl_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import hfl_pkg::*;

  cfg_t cfg;
  out_item_t result;
  logic take;
  logic out_valid;

  hfl_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign take = in_ch.valid && in_ch.ready;

  hfl_core u_core (
    .clk(clk), .rst(rst), .take(take), .item(in_ch.data), .cfg(cfg), .result(result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_ch.data <= result;
    end
  end

  assign out_ch.valid = out_valid;
endmodule

// ===== dv/tb_hood_fan_lamp_controller_top.sv =====
//------------------------------------------------------------------------------
// tb_hood_fan_lamp_controller_top
// Self-checking testbench for the range-hood controller. A queue-fed driver
// sends control steps and ticks, an internal model predicts every result
// snapshot, and a monitor compares each result transaction field by field.
// Both key schemes and several register settings are covered, mostly under random
// backpressure on both channels; the last random phases run with none.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hood_fan_lamp_controller_top;
  import hfl_pkg::*;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  hfl_in_if in_if ();
  hfl_out_if out_if ();

  hood_fan_lamp_controller_top DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_if),
    .out_ch(out_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Pending items, expected snapshots and run bookkeeping.
  in_item_t pending_items[$];
  out_item_t expected_snapshots[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;

  // Model copy of the configuration.
  logic cfg_wmode;
  logic [7:0] cfg_short;
  logic [7:0] cfg_long;
  logic [15:0] cfg_limit;

  // Model copy of the controller state.
  mode_t mdl_mode;
  logic mdl_changed;
  logic [2:0] mdl_speed;
  logic [2:0] mdl_prev_speed;
  logic mdl_lamp;
  logic mdl_led;
  logic [9:0] mdl_delay;
  logic [9:0] mdl_remain;
  logic [31:0] mdl_run_total;
  logic [15:0] mdl_cutoff;
  logic [7:0] mdl_short_cnt;
  logic [7:0] mdl_long_cnt;
  logic [5:0] mdl_sec;
  logic [5:0] mdl_min;
  logic [4:0] mdl_hour;
  logic mdl_pulse_last;
  logic [4:0] mdl_edit_hour;
  logic [5:0] mdl_edit_min;
  logic mdl_edit_stage;
  logic [1:0] mdl_beep;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void model_reset();
    cfg_wmode = 1'b1;
    cfg_short = 8'd4;
    cfg_long = 8'd100;
    cfg_limit = 16'd10800;
    mdl_mode = M_IDLE;
    mdl_changed = 1'b0;
    mdl_speed = 3'd1;
    mdl_prev_speed = 3'd1;
    mdl_lamp = 1'b0;
    mdl_led = 1'b0;
    mdl_delay = DELAY_MIN;
    mdl_remain = '0;
    mdl_run_total = '0;
    mdl_cutoff = 16'd10800;
    mdl_short_cnt = '0;
    mdl_long_cnt = '0;
    mdl_sec = '0;
    mdl_min = '0;
    mdl_hour = 5'd12;
    mdl_pulse_last = 1'b0;
    mdl_edit_hour = '0;
    mdl_edit_min = '0;
    mdl_edit_stage = 1'b0;
    mdl_beep = BEEP_NONE;
  endfunction

  function automatic void go_mode(mode_t m);
    mdl_changed = (m != mdl_mode);
    mdl_mode = m;
  endfunction

  function automatic void sound(logic [1:0] b);
    if (b > mdl_beep) mdl_beep = b;
  endfunction

  function automatic void set_speed(logic [2:0] s);
    mdl_speed = (s >= 3'd1 && s <= 3'd4) ? s : 3'd0;
  endfunction

  // Clock scheme: stepping past either end stops the fan and goes idle.
  function automatic void speed_up_stop();
    if (mdl_speed == 3'd4) begin
      set_speed(3'd0);
      go_mode(M_IDLE);
    end else begin
      set_speed(mdl_speed + 3'd1);
    end
  endfunction

  function automatic void speed_down_stop();
    if (mdl_speed == 3'd1) begin
      set_speed(3'd0);
      go_mode(M_IDLE);
    end else if (mdl_speed == 3'd0) begin
      set_speed(3'd0);
    end else begin
      set_speed(mdl_speed - 3'd1);
    end
  endfunction

  function automatic void delay_up();
    mdl_delay = (mdl_delay == DELAY_MAX) ? DELAY_MIN : mdl_delay + DELAY_MIN;
  endfunction

  function automatic void delay_down();
    mdl_delay = (mdl_delay == DELAY_MIN) ? DELAY_MAX : mdl_delay - DELAY_MIN;
  endfunction

  // Clock-scheme key handling, including the wall clock advance.
  function automatic void clock_scheme_step(in_item_t it, logic stick, logic ltick);
    logic up;
    logic dn;
    up = it.key_press[K_PLUS] || (it.key_hold[K_PLUS] && stick);
    dn = it.key_press[K_MINUS] || (it.key_hold[K_MINUS] && stick);
    if (it.clock_pulse_level != mdl_pulse_last) begin
      mdl_pulse_last = it.clock_pulse_level;
      if (mdl_sec == 6'd59) begin
        mdl_sec = '0;
        if (mdl_min == 6'd59) begin
          mdl_min = '0;
          mdl_hour = (mdl_hour == 5'd23) ? 5'd0 : mdl_hour + 5'd1;
        end else begin
          mdl_min = mdl_min + 6'd1;
        end
      end else begin
        mdl_sec = mdl_sec + 6'd1;
      end
    end
    case (mdl_mode)
      M_IDLE: begin
        set_speed(3'd0);
        if (it.key_press[K_TIMER]) begin
          sound(BEEP_ONE);
          mdl_edit_hour = mdl_hour;
          mdl_edit_min = mdl_min;
          mdl_edit_stage = 1'b0;
          go_mode(M_CLK_EDIT);
        end
        if (it.key_press[K_PLUS]) begin
          sound(BEEP_ONE);
          go_mode(M_BLOW);
          set_speed(3'd1);
        end
        if (it.key_press[K_MINUS]) begin
          sound(BEEP_ONE);
          go_mode(M_BLOW);
          set_speed(3'd4);
        end
      end
      M_CLK_EDIT: begin
        set_speed(3'd0);
        if (!mdl_edit_stage) begin
          if (ltick || it.key_press[K_TIMER]) begin
            mdl_edit_stage = 1'b1;
            mdl_long_cnt = cfg_long;
            sound(BEEP_ONE);
          end
          if (up) begin
            sound(BEEP_ONE);
            mdl_edit_hour = (mdl_edit_hour == 5'd23) ? 5'd0 : mdl_edit_hour + 5'd1;
          end
          if (dn) begin
            sound(BEEP_ONE);
            mdl_edit_hour = (mdl_edit_hour == 5'd0) ? 5'd23 : mdl_edit_hour - 5'd1;
          end
        end else begin
          if (ltick || it.key_press[K_TIMER]) begin
            go_mode(M_IDLE);
            mdl_min = mdl_edit_min;
            mdl_hour = mdl_edit_hour;
            mdl_sec = '0;
            sound(BEEP_TWO);
          end
          if (up) begin
            sound(BEEP_ONE);
            mdl_edit_min = (mdl_edit_min == 6'd59) ? 6'd0 : mdl_edit_min + 6'd1;
          end
          if (dn) begin
            sound(BEEP_ONE);
            mdl_edit_min = (mdl_edit_min == 6'd0) ? 6'd59 : mdl_edit_min - 6'd1;
          end
        end
      end
      M_BLOW: begin
        if (it.key_press[K_TIMER]) begin
          sound(BEEP_ONE);
          mdl_delay = DELAY_MIN;
          go_mode(M_AUTO_EDIT);
        end
        if (it.key_press[K_PLUS]) begin
          sound(BEEP_ONE);
          speed_up_stop();
        end
        if (it.key_press[K_MINUS]) begin
          sound(BEEP_ONE);
          speed_down_stop();
        end
      end
      M_AUTO_EDIT: begin
        if (ltick) begin
          mdl_remain = mdl_delay;
          go_mode(M_BLOW_AUTO);
          sound(BEEP_TWO);
        end
        if (it.key_press[K_TIMER]) begin
          sound(BEEP_ONE);
          go_mode(M_BLOW);
        end
        if (up) begin
          sound(BEEP_ONE);
          mdl_delay = (mdl_delay > DELAY_HI) ? DELAY_MIN : mdl_delay + DELAY_MIN;
        end
        if (dn) begin
          sound(BEEP_ONE);
          mdl_delay = (mdl_delay < DELAY_LO) ? DELAY_MAX : mdl_delay - DELAY_MIN;
        end
      end
      M_BLOW_AUTO: begin
        if (mdl_remain == '0) begin
          sound(BEEP_ONE);
          go_mode(M_IDLE);
          mdl_lamp = 1'b0;
        end
        if (it.key_press[K_PLUS]) begin
          sound(BEEP_ONE);
          speed_up_stop();
        end
        if (it.key_press[K_MINUS]) begin
          sound(BEEP_ONE);
          speed_down_stop();
        end
        if (it.key_release[K_TIMER] && !it.timer_held_late) begin
          sound(BEEP_ONE);
          go_mode(M_BLOW);
        end
      end
      default: go_mode(M_IDLE);
    endcase
  endfunction

  // Run-time scheme key handling.
  function automatic void runtime_scheme_step(in_item_t it, logic stick, logic ltick,
                                              logic [2:0] start_speed,
                                              logic [2:0] last_speed);
    logic was_blow;
    case (mdl_mode)
      M_DELAY_EDIT: begin
        set_speed(3'd0);
        if (it.key_touch != '0) mdl_long_cnt = cfg_long;
        if (ltick && !mdl_changed) begin
          sound(BEEP_ONE);
          go_mode(M_IDLE);
        end
        if (it.key_press[K_PLUS]) begin
          sound(BEEP_ONE);
          delay_up();
        end
        if (it.key_hold[K_PLUS] && stick) begin
          sound(BEEP_ONE);
          delay_up();
        end
        if (it.key_press[K_MINUS]) begin
          sound(BEEP_ONE);
          delay_down();
        end
        if (it.key_hold[K_MINUS] && !mdl_changed && stick) begin
          sound(BEEP_ONE);
          delay_down();
        end
        if (it.key_press[K_TIMER]) begin
          sound(BEEP_ONE);
          go_mode(M_IDLE);
        end
        if (it.key_release[K_MINUS] && mdl_changed) begin
          mdl_changed = 1'b0;
          mdl_long_cnt = cfg_long;
        end
      end
      M_IDLE: begin
        set_speed(3'd0);
        if (it.key_press[K_TIMER]) begin
          sound(BEEP_ONE);
          go_mode(M_BLOW);
          set_speed(last_speed);
        end
        if (it.key_hold[K_PLUS]) begin
          sound(BEEP_ONE);
          mdl_run_total = '0;
          go_mode(M_BLOW);
          set_speed(last_speed);
        end
        if (it.key_hold[K_MINUS]) begin
          sound(BEEP_ONE);
          go_mode(M_DELAY_EDIT);
        end
      end
      M_BLOW, M_BLOW_AUTO: begin
        if (mdl_mode == M_BLOW_AUTO && mdl_remain == '0) begin
          sound(BEEP_ONE);
          go_mode(M_IDLE);
          mdl_lamp = 1'b0;
        end
        was_blow = (mdl_mode == M_BLOW);
        if (it.key_press[K_PLUS]) begin
          sound(BEEP_ONE);
          set_speed((mdl_speed == 3'd4) ? 3'd1 : mdl_speed + 3'd1);
        end
        if (it.key_press[K_MINUS]) begin
          sound(BEEP_ONE);
          if (mdl_speed == 3'd1) set_speed(3'd4);
          else if (mdl_speed == 3'd0) set_speed(3'd0);
          else set_speed(mdl_speed - 3'd1);
        end
        if (it.key_release[K_TIMER] && !mdl_changed) begin
          sound(BEEP_ONE);
          go_mode(M_IDLE);
        end
        if (was_blow && it.key_hold[K_TIMER] && !mdl_changed) begin
          sound(BEEP_ONE);
          go_mode(M_BLOW_AUTO);
          mdl_remain = mdl_delay;
        end
        if (it.key_release[K_TIMER] && mdl_changed) mdl_changed = 1'b0;
        if (start_speed < 3'd5) mdl_prev_speed = start_speed;
      end
      default: go_mode(M_IDLE);
    endcase
  endfunction

  // Advance the model by one accepted item and queue the expected snapshot.
  function automatic void predict_snapshot(in_item_t it);
    logic stick;
    logic ltick;
    logic [2:0] start_speed;
    logic [2:0] last_speed;
    out_item_t snap;
    mdl_beep = BEEP_NONE;
    case (op_t'(it.opcode))
      OP_STEP: begin
        start_speed = mdl_speed;
        last_speed = mdl_prev_speed;
        stick = 1'b0;
        ltick = 1'b0;
        if (mdl_short_cnt == '0) begin
          mdl_short_cnt = cfg_short;
          stick = 1'b1;
        end
        if (mdl_long_cnt == '0) begin
          mdl_long_cnt = cfg_long;
          ltick = 1'b1;
        end
        if (mdl_mode != M_CLK_EDIT && it.key_press[K_LIGHT]) begin
          sound(BEEP_ONE);
          mdl_lamp = ~mdl_lamp;
        end
        mdl_led = !(mdl_mode == M_IDLE && !mdl_lamp && it.key_hold == '0);
        if (it.key_touch != '0) begin
          mdl_cutoff = cfg_limit;
          mdl_long_cnt = cfg_long;
        end
        if (!cfg_wmode) clock_scheme_step(it, stick, ltick);
        else runtime_scheme_step(it, stick, ltick, start_speed, last_speed);
      end
      OP_TICK50: begin
        if (mdl_short_cnt != '0) mdl_short_cnt = mdl_short_cnt - 8'd1;
        if (mdl_long_cnt != '0) mdl_long_cnt = mdl_long_cnt - 8'd1;
      end
      OP_TICK1S: begin
        if (mdl_mode == M_BLOW || mdl_mode == M_BLOW_AUTO) begin
          mdl_run_total = mdl_run_total + 32'd1;
          if (mdl_mode == M_BLOW_AUTO && mdl_remain != '0) mdl_remain = mdl_remain - 10'd1;
          if (mdl_cutoff == '0) begin
            sound(BEEP_ONE);
            go_mode(M_IDLE);
            mdl_lamp = 1'b0;
          end else begin
            mdl_cutoff = mdl_cutoff - 16'd1;
          end
        end
      end
      default: ;
    endcase
    snap.fan_drive = (mdl_speed >= 3'd1 && mdl_speed <= 3'd4) ?
                     4'd1 << (mdl_speed - 3'd1) : 4'd0;
    snap.lamp_on = mdl_lamp;
    snap.led_on = mdl_led;
    snap.beep = mdl_beep;
    snap.mode_state = mdl_mode;
    snap.clock_hour = mdl_hour;
    snap.clock_minute = mdl_min;
    snap.edit_hour = mdl_edit_hour;
    snap.edit_minute = mdl_edit_min;
    snap.off_delay_seconds = mdl_delay;
    snap.off_remain_seconds = mdl_remain;
    snap.run_seconds_total = mdl_run_total;
    expected_snapshots.push_back(snap);
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    error_count++;
  endtask

  // Driver: feeds the input channel from the pending queue.
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) predict_snapshot(in_if.data);
      if (!in_if.valid || in_if.ready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          in_if.data <= pending_items.pop_front();
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    if (rst) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Monitor: compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_snapshots.size() == 0) begin
        $display("[%0t] unexpected result transaction", $realtime);
        error_count++;
      end else begin
        want = expected_snapshots.pop_front();
        if (got.fan_drive !== want.fan_drive)
          report_mismatch("fan_drive", 32'(got.fan_drive), 32'(want.fan_drive));
        if (got.lamp_on !== want.lamp_on)
          report_mismatch("lamp_on", 32'(got.lamp_on), 32'(want.lamp_on));
        if (got.led_on !== want.led_on)
          report_mismatch("led_on", 32'(got.led_on), 32'(want.led_on));
        if (got.beep !== want.beep)
          report_mismatch("beep", 32'(got.beep), 32'(want.beep));
        if (got.mode_state !== want.mode_state)
          report_mismatch("mode_state", 32'(got.mode_state), 32'(want.mode_state));
        if (got.clock_hour !== want.clock_hour)
          report_mismatch("clock_hour", 32'(got.clock_hour), 32'(want.clock_hour));
        if (got.clock_minute !== want.clock_minute)
          report_mismatch("clock_minute", 32'(got.clock_minute), 32'(want.clock_minute));
        if (got.edit_hour !== want.edit_hour)
          report_mismatch("edit_hour", 32'(got.edit_hour), 32'(want.edit_hour));
        if (got.edit_minute !== want.edit_minute)
          report_mismatch("edit_minute", 32'(got.edit_minute), 32'(want.edit_minute));
        if (got.off_delay_seconds !== want.off_delay_seconds)
          report_mismatch("off_delay_seconds", 32'(got.off_delay_seconds),
                          32'(want.off_delay_seconds));
        if (got.off_remain_seconds !== want.off_remain_seconds)
          report_mismatch("off_remain_seconds", 32'(got.off_remain_seconds),
                          32'(want.off_remain_seconds));
        if (got.run_seconds_total !== want.run_seconds_total)
          report_mismatch("run_seconds_total", got.run_seconds_total, want.run_seconds_total);
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle; the model follows.
  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WMODE: cfg_wmode = value[0];
      REG_SHORT: cfg_short = value[7:0];
      REG_LONG: cfg_long = value[7:0];
      default: cfg_limit = value[15:0];
    endcase
  endtask

  // Wait until every queued item is sent and every result has arrived.
  task automatic wait_drained();
    while (pending_items.size() > 0 || in_if.valid || expected_snapshots.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic in_item_t make_item(logic [1:0] op, logic [3:0] pr, logic [3:0] hd,
                                         logic [3:0] rl, logic [3:0] tc, logic late,
                                         logic lvl);
    in_item_t it;
    it.opcode = op;
    it.key_press = pr;
    it.key_hold = hd;
    it.key_release = rl;
    it.key_touch = tc;
    it.timer_held_late = late;
    it.clock_pulse_level = lvl;
    return it;
  endfunction

  // Random item: mostly single key events and ticks, sparse touches, a little noise.
  function automatic in_item_t rand_item();
    int unsigned sel;
    logic [3:0] pr;
    logic [3:0] hd;
    logic [3:0] rl;
    logic [3:0] tc;
    logic [1:0] op;
    sel = $urandom_range(0, 99);
    if (sel < 50) op = OP_STEP;
    else if (sel < 75) op = OP_TICK50;
    else if (sel < 96) op = OP_TICK1S;
    else op = OP_NONE;
    pr = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
         ($urandom_range(0, 1) ? 4'd1 << $urandom_range(0, 3) : 4'd0);
    hd = ($urandom_range(0, 3) == 0) ? 4'd1 << $urandom_range(0, 3) :
         (($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15)) : 4'd0);
    rl = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
    tc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
    return make_item(op, pr, hd, rl, tc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // Main sequence.
  initial begin
    int p;
    int n;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    error_count = 0;
    cycle_count = 0;
    src_idle_pct = 8;
    snk_idle_pct = 70;
    model_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, run-time scheme at reset settings: every opcode, key extremes.
    pending_items.push_back(make_item(OP_NONE, 4'hF, 4'hF, 4'hF, 4'hF, 1'b1, 1'b1));
    pending_items.push_back(make_item(OP_TICK50, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 1'b0));
    pending_items.push_back(make_item(OP_STEP, 4'h2, 4'h0, 4'h0, 4'h2, 1'b0, 1'b0));
    pending_items.push_back(make_item(OP_STEP, 4'h5, 4'h0, 4'h0, 4'h0, 1'b0, 1'b1));
    pending_items.push_back(make_item(OP_STEP, 4'h8, 4'h2, 4'h0, 4'h0, 1'b0, 1'b0));
    pending_items.push_back(make_item(OP_TICK1S, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 1'b0));
    pending_items.push_back(make_item(OP_STEP, 4'h0, 4'h2, 4'h2, 4'h0, 1'b1, 1'b0));
    pending_items.push_back(make_item(OP_STEP, 4'h0, 4'h0, 4'h2, 4'h0, 1'b0, 1'b0));
    pending_items.push_back(make_item(OP_STEP, 4'h0, 4'h8, 4'h0, 4'hF, 1'b0, 1'b0));
    pending_items.push_back(make_item(OP_STEP, 4'hC, 4'hC, 4'h8, 4'h0, 1'b0, 1'b0));
    pending_items.push_back(make_item(OP_STEP, 4'hF, 4'hF, 4'hF, 4'hF, 1'b1, 1'b1));
    pending_items.push_back(make_item(OP_STEP, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 1'b0));
    wait_drained();

    // Directed, clock scheme with a zero cutoff and zero-length repeat counter.
    cfg_write(REG_WMODE, 32'd0);
    cfg_write(REG_SHORT, 32'd0);
    cfg_write(REG_LONG, 32'd1);
    cfg_write(REG_LIMIT, 32'd0);
    pending_items.push_back(make_item(OP_STEP, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 1'b0));
    pending_items.push_back(make_item(OP_STEP, 4'h2, 4'h0, 4'h0, 4'h0, 1'b0, 1'b1));
    pending_items.push_back(make_item(OP_STEP, 4'h0, 4'h8, 4'h0, 4'h0, 1'b0, 1'b0));
    pending_items.push_back(make_item(OP_STEP, 4'h2, 4'h4, 4'h0, 4'h0, 1'b0, 1'b1));
    pending_items.push_back(make_item(OP_STEP, 4'h2, 4'h0, 4'h0, 4'h0, 1'b0, 1'b0));
    pending_items.push_back(make_item(OP_STEP, 4'h8, 4'h0, 4'h0, 4'h0, 1'b0, 1'b0));
    pending_items.push_back(make_item(OP_STEP, 4'h8, 4'h0, 4'h0, 4'h0, 1'b0, 1'b0));
    pending_items.push_back(make_item(OP_TICK1S, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 1'b0));
    pending_items.push_back(make_item(OP_TICK1S, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 1'b0));
    pending_items.push_back(make_item(OP_STEP, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 1'b1));
    wait_drained();

    // Random phases over several settings and the three idling regimes.
    for (p = 0; p < 9; p++) begin
      if (p < 3) begin
        src_idle_pct = 8;
        snk_idle_pct = 70;
      end else if (p < 6) begin
        src_idle_pct = 70;
        snk_idle_pct = 8;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      cfg_write(REG_WMODE, p % 2);
      cfg_write(REG_SHORT, (p == 0) ? 1 : (p == 1) ? 255 : $urandom_range(1, 8));
      cfg_write(REG_LONG, (p == 3) ? 1 : (p == 4) ? 255 : $urandom_range(2, 30));
      cfg_write(REG_LIMIT, (p == 5) ? 0 : (p == 6) ? 65535 : $urandom_range(0, 40));
      for (n = 0; n < 100; n++) pending_items.push_back(rand_item());
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
